// ===== hdl/sfna_pkg.sv =====
// Shared types and constants for the smallest-free-number allocator.
// Used by sfna_cell and smallest_free_number_allocator_unit; no dependencies.
package sfna_pkg;

    localparam int NUMBER_SPACE_DEF = 1024;
    localparam int NUMBER_W         = 10;
    localparam int CELL_LW          = 5;              // log2 of marks per cell
    localparam int CELL_W           = 1 << CELL_LW;   // marks held by one cell
    localparam int CELL_IW          = 11;             // up to 2048 cells
    localparam int IDX_W            = CELL_IW + CELL_LW;
    localparam int CMP_W            = 17;             // holds any watermark up to 65536

    localparam logic ACT_TAKE = 1'b0;
    localparam logic ACT_GIVE = 1'b1;

    // Command broadcast to every cell in the execute cycle
    typedef struct packed {
        logic [CELL_IW-1:0] cell_sel;
        logic [CELL_LW-1:0] bit_idx;
        logic               set;
        logic               clr_first;
    } t_cell_cmd;

    // Status returned by each cell
    typedef struct packed {
        logic               hit;
        logic               win;
        logic [CELL_LW-1:0] first;
    } t_cell_stat;

endpackage

// ===== hdl/sfna_cell.sv =====
// One cell of the mark chain: holds CELL_W returned-number marks.
// Depends on sfna_pkg. Passes a "mark found lower down" flag to its neighbour.
module sfna_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sfna_pkg::t_cell_cmd  i_cmd,
    input  logic                 i_found_in,
    output logic                 o_found_out,
    output sfna_pkg::t_cell_stat o_stat
);
    import sfna_pkg::*;

    logic [CELL_W-1:0]  r_word;
    logic [CELL_W-1:0]  n_word;
    logic               any;
    logic               sel;
    logic               win;
    logic [CELL_LW-1:0] first;

    assign any = |r_word;
    assign sel = (i_cmd.cell_sel == CELL_IW'(CELL_IDX));
    assign win = any & ~i_found_in;

    // lowest set mark in this cell
    always_comb begin
        first = '0;
        for (int i = CELL_W - 1; i >= 0; i--) begin
            if (r_word[i]) begin
                first = CELL_LW'(i);
            end
        end
    end

    always_comb begin
        n_word = r_word;
        if (i_cmd.set && sel) begin
            n_word[i_cmd.bit_idx] = 1'b1;
        end
        if (i_cmd.clr_first && win) begin
            n_word[first] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word <= '0;
        end else begin
            r_word <= n_word;
        end
    end

    assign o_found_out  = i_found_in | any;
    assign o_stat.hit   = sel & r_word[i_cmd.bit_idx];
    assign o_stat.win   = win;
    assign o_stat.first = first;

endmodule

// ===== hdl/smallest_free_number_allocator_unit.sv =====
// Smallest-free-number allocator: hands out numbers lowest first from 1 and takes them back.
// Depends on sfna_pkg and sfna_cell.
//
// A request is taken when start is high and busy is low; each request is accepted and then handled
// in the execute state, where the cell chain is searched and updated, so busy is high for the cycle
// after each transfer. A take gives one result, shown for a single cycle with o_valid high in the
// cycle after the execute cycle; the receiver cannot stall it, so it must
// capture the result then. A give-back gives no result. The lowest returned number is found by
// a chain of 32-mark cells that pass a "found below" flag along, which sets the execute cycle.
// No clearing pass is needed after reset.
module smallest_free_number_allocator_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_action,
    input  logic [sfna_pkg::NUMBER_W-1:0] i_number,
    output logic                          o_valid,
    output logic [sfna_pkg::NUMBER_W-1:0] o_taken_number,
    output logic                          o_exhausted
);
    import sfna_pkg::*;

    localparam int NUMBER_SPACE = NUMBER_SPACE_DEF;
    localparam int NCELL = (NUMBER_SPACE + CELL_W - 1) / CELL_W;
    localparam int WM_W  = $clog2(NUMBER_SPACE + 1);

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

    t_state                r_state, n_state;
    logic [WM_W-1:0]       r_wm, n_wm;
    logic                  r_action;
    logic [NUMBER_W-1:0]   r_number;
    logic                  r_valid, n_valid;
    logic [NUMBER_W-1:0]   r_taken, n_taken;
    logic                  r_exh, n_exh;

    t_cell_cmd             cmd;
    t_cell_stat            stat [NCELL];
    logic [NCELL:0]        found;
    logic [IDX_W-1:0]      win_idx;
    logic                  hit;
    logic [CMP_W-1:0]      num_c;
    logic [CMP_W-1:0]      wm_c;

    assign found[0] = 1'b0;

    for (genvar k = 0; k < NCELL; k++) begin : g_cell
        sfna_cell #(
            .CELL_IDX(k)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cmd      (cmd),
            .i_found_in (found[k]),
            .o_found_out(found[k+1]),
            .o_stat     (stat[k])
        );
    end

    // only one cell can win or hit, so an OR gathers the answer
    always_comb begin
        win_idx = '0;
        hit     = 1'b0;
        for (int k = 0; k < NCELL; k++) begin
            if (stat[k].win) begin
                win_idx = win_idx | {CELL_IW'(k), stat[k].first};
            end
            hit = hit | stat[k].hit;
        end
    end

    assign num_c = CMP_W'(r_number);
    assign wm_c  = CMP_W'(r_wm);

    always_comb begin
        n_state       = r_state;
        n_wm          = r_wm;
        n_valid       = 1'b0;
        n_taken       = r_taken;
        n_exh         = r_exh;
        cmd.cell_sel  = CELL_IW'(r_number >> CELL_LW);
        cmd.bit_idx   = r_number[CELL_LW-1:0];
        cmd.set       = 1'b0;
        cmd.clr_first = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state = ST_IDLE;
                if (r_action == ACT_TAKE) begin
                    n_valid = 1'b1;
                    if (found[NCELL]) begin
                        cmd.clr_first = 1'b1;
                        n_taken       = win_idx[NUMBER_W-1:0];
                        n_exh         = 1'b0;
                    end else if (wm_c < CMP_W'(NUMBER_SPACE)) begin
                        n_taken = r_wm[NUMBER_W-1:0];
                        n_exh   = 1'b0;
                        n_wm    = r_wm + WM_W'(1);
                    end else begin
                        n_taken = '0;
                        n_exh   = 1'b1;
                    end
                end else begin
                    if (num_c != '0 && num_c < wm_c && !hit) begin
                        if (num_c == wm_c - CMP_W'(1)) begin
                            n_wm = r_wm - WM_W'(1);
                        end else begin
                            cmd.set = 1'b1;
                        end
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_wm    <= WM_W'(1);
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wm    <= n_wm;
            r_valid <= n_valid;
        end
        if (r_state == ST_IDLE && start) begin
            r_action <= i_action;
            r_number <= i_number;
        end
        r_taken <= n_taken;
        r_exh   <= n_exh;
    end

    assign busy           = (r_state != ST_IDLE);
    assign o_valid        = r_valid;
    assign o_taken_number = r_taken;
    assign o_exhausted    = r_exh;

endmodule
